// File: rtl/cmr_pkg.sv
`timescale 1ns / 1ps

package cmr_pkg;

    localparam int WORD_BITS = 32;
    localparam int POS_W     = 5;
    localparam int NUM_POS   = WORD_BITS - 1;

    localparam logic [WORD_BITS-1:0] MAG_LIMIT = {2'b01, {(WORD_BITS-2){1'b0}}};

    localparam int PC_W   = 3;
    localparam int OP_W   = 3;
    localparam int COND_W = 3;

    localparam logic [OP_W-1:0] OP_ACCEPT = 3'd0;
    localparam logic [OP_W-1:0] OP_CHECK  = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
    localparam logic [OP_W-1:0] OP_DECIDE = 3'd3;
    localparam logic [OP_W-1:0] OP_EMIT   = 3'd4;
    localparam logic [OP_W-1:0] OP_ERROR  = 3'd5;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd6;

    localparam logic [COND_W-1:0] C_NEVER  = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
    localparam logic [COND_W-1:0] C_BAD    = 3'd2;
    localparam logic [COND_W-1:0] C_MORE   = 3'd3;
    localparam logic [COND_W-1:0] C_TERMS  = 3'd4;

    localparam logic [PC_W-1:0] PC_ACCEPT = 3'd0;
    localparam logic [PC_W-1:0] PC_CHECK  = 3'd1;
    localparam logic [PC_W-1:0] PC_FIND   = 3'd2;
    localparam logic [PC_W-1:0] PC_DECIDE = 3'd3;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd4;
    localparam logic [PC_W-1:0] PC_WRAP   = 3'd5;
    localparam logic [PC_W-1:0] PC_ERROR  = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_ACCEPT: w = '{op: OP_ACCEPT, cond: C_NEVER,  target: PC_ACCEPT};
            PC_CHECK:  w = '{op: OP_CHECK,  cond: C_BAD,    target: PC_ERROR};
            PC_FIND:   w = '{op: OP_FIND,   cond: C_NEVER,  target: PC_ACCEPT};
            PC_DECIDE: w = '{op: OP_DECIDE, cond: C_MORE,   target: PC_FIND};
            PC_EMIT:   w = '{op: OP_EMIT,   cond: C_TERMS,  target: PC_EMIT};
            PC_WRAP:   w = '{op: OP_NOP,    cond: C_ALWAYS, target: PC_ACCEPT};
            PC_ERROR:  w = '{op: OP_ERROR,  cond: C_ALWAYS, target: PC_ACCEPT};
            default:   w = '{op: OP_NOP,    cond: C_ALWAYS, target: PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/cmr_operand_if.sv
`timescale 1ns / 1ps

interface cmr_operand_if;
    import cmr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] multiplier;

    modport source (output valid, output multiplier, input ready);
    modport sink   (input valid, input multiplier, output ready);
endinterface

// File: rtl/cmr_term_if.sv
`timescale 1ns / 1ps

interface cmr_term_if;
    import cmr_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] shift_step;
    logic             negate;
    logic             first_term;
    logic             last_term;
    logic             bad_constant;

    modport source (output valid, output position, output shift_step, output negate,
                    output first_term, output last_term, output bad_constant,
                    input ready);
    modport sink   (input valid, input position, input shift_step, input negate,
                    input first_term, input last_term, input bad_constant,
                    output ready);
endinterface

// File: rtl/constant_multiply_recoder.sv
`timescale 1ns / 1ps

// Recodes a signed multiplier constant into signed power-of-two terms.
// operand: one beat carries the 32-bit signed constant; ready is high only while
//   the sequencer sits on its accept step.
// term: one beat per nonzero digit, lowest position first, with the shift from
//   the previous term, a negate bit and first/last marks. A zero constant or a
//   magnitude above 2^30 gives one beat with bad_constant, first and last set.
// Sequencing: a small microcode table steps a plain datapath; each recoding pass
//   takes two steps (bound search, then nearest-power choice), each term one.
//   All passes finish before the first term is emitted; a bad constant goes from
//   the range check straight to the error step.
// A finished term waits in the output register; the next constant can be taken
//   while the last term of the previous one still waits there.
// When the receiver stalls, the sequencer holds on its emit or error step and
//   nothing is lost. Reset returns the sequencer to its accept step and empties
//   the output register.
module constant_multiply_recoder (
    input  logic         clk,
    input  logic         rst_n,
    cmr_operand_if.sink  operand,
    cmr_term_if.source   term
);
    import cmr_pkg::*;

    logic [PC_W-1:0]      pc_reg;
    logic [PC_W-1:0]      pc_next;
    ucode_t               uw;

    logic [WORD_BITS-1:0] mag_reg;
    logic [WORD_BITS-1:0] mag_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [POS_W-1:0]     k_reg;
    logic [POS_W-1:0]     k_next;
    logic [NUM_POS-1:0]   used_reg;
    logic [NUM_POS-1:0]   used_next;
    logic [NUM_POS-1:0]   dneg_reg;
    logic [NUM_POS-1:0]   dneg_next;
    logic                 first_reg;
    logic                 first_next;
    logic [POS_W-1:0]     prev_reg;
    logic [POS_W-1:0]     prev_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [POS_W-1:0]     position_reg;
    logic [POS_W-1:0]     position_next;
    logic [POS_W-1:0]     shift_step_reg;
    logic [POS_W-1:0]     shift_step_next;
    logic                 negate_reg;
    logic                 negate_next;
    logic                 first_term_reg;
    logic                 first_term_next;
    logic                 last_term_reg;
    logic                 last_term_next;
    logic                 bad_constant_reg;
    logic                 bad_constant_next;

    logic [WORD_BITS-1:0] abs_val;
    logic                 bad;
    logic [WORD_BITS-1:0] mag_m1;
    logic [POS_W-1:0]     k_find;
    logic [WORD_BITS-1:0] hi;
    logic [WORD_BITS-1:0] lo;
    logic [WORD_BITS-1:0] d1;
    logic [WORD_BITS-1:0] d2;
    logic                 take_hi;
    logic [POS_W-1:0]     pick;
    logic [WORD_BITS-1:0] mag_dec;
    logic                 more;
    logic [POS_W-1:0]     low_pos;
    logic [NUM_POS-1:0]   rest;
    logic                 last;
    logic                 slot_free;
    logic                 stall;
    logic                 cond_true;

    assign uw = ucode_rom(pc_reg);

    assign abs_val = operand.multiplier[WORD_BITS-1]
                   ? (~operand.multiplier + 1'b1) : operand.multiplier;
    assign bad     = (mag_reg == '0) || (mag_reg > MAG_LIMIT);

    assign mag_m1 = mag_reg - 1'b1;
    always_comb
    begin
        k_find = POS_W'(1);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (mag_m1[i])
            begin
                k_find = POS_W'(i + 1);
            end
        end
    end

    assign hi      = {{(WORD_BITS-1){1'b0}}, 1'b1} << k_reg;
    assign lo      = hi >> 1;
    assign d1      = mag_reg - lo;
    assign d2      = hi - mag_reg;
    assign take_hi = d2 < d1;
    assign pick    = take_hi ? k_reg : (k_reg - 1'b1);
    assign mag_dec = take_hi ? d2 : d1;
    assign more    = mag_dec != '0;

    always_comb
    begin
        low_pos = '0;
        for (int i = NUM_POS - 1; i >= 0; i--)
        begin
            if (used_reg[i])
            begin
                low_pos = POS_W'(i);
            end
        end
    end

    assign rest = used_reg & ~({{(NUM_POS-1){1'b0}}, 1'b1} << low_pos);
    assign last = rest == '0;

    assign slot_free = !out_valid_reg || term.ready;
    assign stall     = ((uw.op == OP_ACCEPT) && !operand.valid)
                    || (((uw.op == OP_EMIT) || (uw.op == OP_ERROR)) && !slot_free);

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:  cond_true = 1'b0;
            C_ALWAYS: cond_true = 1'b1;
            C_BAD:    cond_true = bad;
            C_MORE:   cond_true = more;
            C_TERMS:  cond_true = !last;
            default:  cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (cond_true)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_comb
    begin
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        k_next            = k_reg;
        used_next         = used_reg;
        dneg_next         = dneg_reg;
        first_next        = first_reg;
        prev_next         = prev_reg;
        out_valid_next    = out_valid_reg && !term.ready;
        position_next     = position_reg;
        shift_step_next   = shift_step_reg;
        negate_next       = negate_reg;
        first_term_next   = first_term_reg;
        last_term_next    = last_term_reg;
        bad_constant_next = bad_constant_reg;

        if (!stall)
        begin
            unique case (uw.op)
                OP_ACCEPT:
                begin
                    mag_next   = abs_val;
                    neg_next   = operand.multiplier[WORD_BITS-1];
                    used_next  = '0;
                    dneg_next  = '0;
                    first_next = 1'b1;
                    prev_next  = '0;
                end
                OP_FIND:
                begin
                    k_next = k_find;
                end
                OP_DECIDE:
                begin
                    used_next[pick] = 1'b1;
                    dneg_next[pick] = neg_reg;
                    mag_next        = mag_dec;
                    if (take_hi)
                    begin
                        neg_next = !neg_reg;
                    end
                end
                OP_EMIT:
                begin
                    out_valid_next    = 1'b1;
                    position_next     = low_pos;
                    shift_step_next   = first_reg ? low_pos : (low_pos - prev_reg);
                    negate_next       = dneg_reg[low_pos];
                    first_term_next   = first_reg;
                    last_term_next    = last;
                    bad_constant_next = 1'b0;
                    used_next         = rest;
                    prev_next         = low_pos;
                    first_next        = 1'b0;
                end
                OP_ERROR:
                begin
                    out_valid_next    = 1'b1;
                    position_next     = '0;
                    shift_step_next   = '0;
                    negate_next       = 1'b0;
                    first_term_next   = 1'b1;
                    last_term_next    = 1'b1;
                    bad_constant_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_ACCEPT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg          <= mag_next;
        neg_reg          <= neg_next;
        k_reg            <= k_next;
        used_reg         <= used_next;
        dneg_reg         <= dneg_next;
        first_reg        <= first_next;
        prev_reg         <= prev_next;
        position_reg     <= position_next;
        shift_step_reg   <= shift_step_next;
        negate_reg       <= negate_next;
        first_term_reg   <= first_term_next;
        last_term_reg    <= last_term_next;
        bad_constant_reg <= bad_constant_next;
    end

    assign operand.ready     = uw.op == OP_ACCEPT;
    assign term.valid        = out_valid_reg;
    assign term.position     = position_reg;
    assign term.shift_step   = shift_step_reg;
    assign term.negate       = negate_reg;
    assign term.first_term   = first_term_reg;
    assign term.last_term    = last_term_reg;
    assign term.bad_constant = bad_constant_reg;

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready |=> pc_reg == PC_CHECK)
        else $error("accepted beat did not advance to the range check");

    a_find_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        uw.op == OP_FIND |-> (mag_reg != '0) && (mag_reg <= MAG_LIMIT))
        else $error("remainder out of range during recoding");

    a_digit_once: assert property (@(posedge clk) disable iff (!rst_n)
        uw.op == OP_DECIDE |-> !used_reg[pick])
        else $error("digit position chosen twice");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        term.valid && term.bad_constant |-> term.first_term && term.last_term)
        else $error("error beat not marked first and last");

endmodule
